// ===== hw/rtl/stack_machine_execute_unit_macros.svh =====
// Assertion macros used by the stack machine execute unit checker.
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication
`define SMEU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stack machine execute unit: assertion failed");

// next-cycle implication
`define SMEU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stack machine execute unit: assertion failed");

`endif

// ===== hw/rtl/smeu_pkg.sv =====
// Types, codes and defaults of the stack machine execute unit.
package smeu_pkg;

   localparam int STACK_DEPTH_DEF   = 1024;
   localparam int GLOBALS_DEPTH_DEF = 256;
   localparam int MAX_PRINT_DEF     = 16;

   localparam logic [5:0] OP_HALT   = 6'd0;
   localparam logic [5:0] OP_NOP    = 6'd1;
   localparam logic [5:0] OP_LOADG  = 6'd2;
   localparam logic [5:0] OP_STOREG = 6'd3;
   localparam logic [5:0] OP_PUSHC  = 6'd4;
   localparam logic [5:0] OP_POP    = 6'd5;
   localparam logic [5:0] OP_SWAP   = 6'd6;
   localparam logic [5:0] OP_DUP    = 6'd7;
   localparam logic [5:0] OP_GOTO   = 6'd8;
   localparam logic [5:0] OP_BR_EQ  = 6'd9;
   localparam logic [5:0] OP_BR_NE  = 6'd10;
   localparam logic [5:0] OP_BR_LT  = 6'd11;
   localparam logic [5:0] OP_BR_LE  = 6'd12;
   localparam logic [5:0] OP_BR_GT  = 6'd13;
   localparam logic [5:0] OP_BR_GE  = 6'd14;
   localparam logic [5:0] OP_BR_Z   = 6'd15;
   localparam logic [5:0] OP_BR_NZ  = 6'd16;
   localparam logic [5:0] OP_ADD    = 6'd17;
   localparam logic [5:0] OP_SUB    = 6'd18;
   localparam logic [5:0] OP_MUL    = 6'd19;
   localparam logic [5:0] OP_DIV    = 6'd20;
   localparam logic [5:0] OP_MOD    = 6'd21;
   localparam logic [5:0] OP_POW    = 6'd22;
   localparam logic [5:0] OP_AND    = 6'd23;
   localparam logic [5:0] OP_OR     = 6'd24;
   localparam logic [5:0] OP_CMP    = 6'd25;
   localparam logic [5:0] OP_EQ     = 6'd26;
   localparam logic [5:0] OP_NE     = 6'd27;
   localparam logic [5:0] OP_LT     = 6'd28;
   localparam logic [5:0] OP_LE     = 6'd29;
   localparam logic [5:0] OP_GT     = 6'd30;
   localparam logic [5:0] OP_GE     = 6'd31;
   localparam logic [5:0] OP_NEG    = 6'd32;
   localparam logic [5:0] OP_NOT    = 6'd33;
   localparam logic [5:0] OP_PRINT  = 6'd34;

   localparam logic CSR_GLOBALS = 1'b0;
   localparam logic CSR_LIMIT   = 1'b1;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_HALTED  = 3'd1,
      ST_OVF     = 3'd2,
      ST_UNDF    = 3'd3,
      ST_BADG    = 3'd4,
      ST_INVOP   = 3'd5,
      ST_DIVZ    = 3'd6,
      ST_BADPRN  = 3'd7
   } smeu_status_type;

   typedef enum logic [3:0] {
      CL_HALT    = 4'd0,
      CL_NOP     = 4'd1,
      CL_LOADG   = 4'd2,
      CL_STOREG  = 4'd3,
      CL_PUSHC   = 4'd4,
      CL_POP     = 4'd5,
      CL_SWAP    = 4'd6,
      CL_DUP     = 4'd7,
      CL_GOTO    = 4'd8,
      CL_BRANCH  = 4'd9,
      CL_BINOP   = 4'd10,
      CL_UNOP    = 4'd11,
      CL_PRINT   = 4'd12,
      CL_INVALID = 4'd13
   } smeu_class_type;

   typedef struct packed {
      logic [5:0]     op;
      smeu_class_type cls;
      logic [1:0]     need;
      logic           print_bad;
      logic [31:0]    operand;
   } smeu_issue_type;

   typedef struct packed {
      smeu_status_type status;
      logic [31:0]     pc_delta;
      logic            print_valid;
      logic [31:0]     print_value;
      logic            last;
   } smeu_rsp_type;

endpackage

// ===== hw/rtl/smeu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module smeu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/smeu_fifo.sv =====
// Two-entry queue used between the front, the back and the result port.
module smeu_fifo #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   output logic             empty,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== hw/rtl/smeu_front.sv =====
// Front end: accepts requests, classifies opcodes and queues them for the back end.
module smeu_front import smeu_pkg::*; #(
   parameter int MAX_PRINT = MAX_PRINT_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           hold,
   input  logic           req_push,
   output logic           req_full,
   input  logic [5:0]     req_type,
   input  logic [31:0]    req_operand,
   output logic           issue_valid,
   input  logic           issue_take,
   output smeu_issue_type issue
);

   smeu_issue_type dec;
   logic           q_full, q_empty;

   always_comb begin
      dec.op        = req_type;
      dec.operand   = req_operand;
      dec.need      = 2'd0;
      dec.print_bad = req_operand[31] || (req_operand == 32'd0) ||
                      (req_operand > 32'(MAX_PRINT));
      if (req_type == OP_HALT) begin
         dec.cls = CL_HALT;
      end else if (req_type == OP_NOP) begin
         dec.cls = CL_NOP;
      end else if (req_type == OP_LOADG) begin
         dec.cls = CL_LOADG;
      end else if (req_type == OP_STOREG) begin
         dec.cls  = CL_STOREG;
         dec.need = 2'd1;
      end else if (req_type == OP_PUSHC) begin
         dec.cls = CL_PUSHC;
      end else if (req_type == OP_POP) begin
         dec.cls = CL_POP;
      end else if (req_type == OP_SWAP) begin
         dec.cls  = CL_SWAP;
         dec.need = 2'd2;
      end else if (req_type == OP_DUP) begin
         dec.cls  = CL_DUP;
         dec.need = 2'd1;
      end else if (req_type == OP_GOTO) begin
         dec.cls = CL_GOTO;
      end else if (req_type >= OP_BR_EQ && req_type <= OP_BR_NZ) begin
         dec.cls  = CL_BRANCH;
         dec.need = (req_type >= OP_BR_Z) ? 2'd1 : 2'd2;
      end else if (req_type >= OP_ADD && req_type <= OP_GE) begin
         dec.cls  = CL_BINOP;
         dec.need = 2'd2;
      end else if (req_type == OP_NEG || req_type == OP_NOT) begin
         dec.cls  = CL_UNOP;
         dec.need = 2'd1;
      end else if (req_type == OP_PRINT) begin
         dec.cls = CL_PRINT;
      end else begin
         dec.cls = CL_INVALID;
      end
   end

   assign req_full    = q_full || hold;
   assign issue_valid = !q_empty;

   smeu_fifo #(
      .WIDTH($bits(smeu_issue_type))
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (req_push && !req_full),
      .full   (q_full),
      .wr_data(dec),
      .empty  (q_empty),
      .pop    (issue_take),
      .rd_data(issue)
   );

endmodule

// ===== hw/rtl/smeu_back.sv =====
// Back end: sequencer that executes queued instructions on the stack and globals.
module smeu_back import smeu_pkg::*; #(
   parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
   parameter int GLOBALS_DEPTH = GLOBALS_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write,
   input  logic           csr_index,
   input  logic [10:0]    csr_data,
   output logic           clearing,
   input  logic           issue_valid,
   output logic           issue_take,
   input  smeu_issue_type issue,
   output logic           rsp_push,
   input  logic           rsp_full,
   output smeu_rsp_type   rsp
);

   localparam int SAW = $clog2(STACK_DEPTH);
   localparam int CW  = $clog2(STACK_DEPTH + 1);
   localparam int LW  = (CW > 11) ? CW : 11;
   localparam int GAW = (GLOBALS_DEPTH > 1) ? $clog2(GLOBALS_DEPTH) : 1;
   localparam int GCW = $clog2(GLOBALS_DEPTH + 1);
   localparam int GEW = (GCW > 9) ? GCW : 9;

   typedef enum logic [14:0] {
      S_CLEAR = 15'h0001,
      S_IDLE  = 15'h0002,
      S_GETB  = 15'h0004,
      S_GETA  = 15'h0008,
      S_GETG  = 15'h0010,
      S_EXEC  = 15'h0020,
      S_DIV   = 15'h0040,
      S_POW   = 15'h0080,
      S_SIGN  = 15'h0100,
      S_WRITE = 15'h0200,
      S_SWAP  = 15'h0400,
      S_RESP  = 15'h0800,
      S_PREAD = 15'h1000,
      S_PWAIT = 15'h2000,
      S_PPUSH = 15'h4000
   } smeu_state_type;

   smeu_state_type  state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [8:0]      gin_ff;
   logic [10:0]     slim_ff;
   logic [GAW-1:0]  clr_ff, clr_in;
   logic [5:0]      op_ff, op_in;
   smeu_class_type  cls_ff, cls_in;
   logic [1:0]      need_ff, need_in;
   logic [31:0]     imm_ff, imm_in;
   logic [31:0]     a_ff, a_in, b_ff, b_in;
   logic [31:0]     res_ff, res_in;
   logic [31:0]     rem_ff, rem_in, quo_ff, quo_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic            sign_ff, sign_in;
   logic [CW-1:0]   pidx_ff, pidx_in, pbase_ff, pbase_in;
   smeu_rsp_type    rsp_ff, rsp_in;

   logic            s_we, s_re, g_we, g_re;
   logic [SAW-1:0]  s_waddr, s_raddr;
   logic [31:0]     s_wdata, s_rdata;
   logic [GAW-1:0]  g_waddr, g_raddr;
   logic [31:0]     g_wdata, g_rdata;

   logic [CW-1:0]   nm1, nm2;
   logic [LW-1:0]   lim_w;
   logic [GEW-1:0]  eg;
   logic            ovf, nz, lt2, badg, plt;
   smeu_status_type fst;
   logic [31:0]     alu, ma, mb, dv;
   logic [32:0]     dt, dd;
   logic            taken;

   assign nm1      = count_ff - CW'(1);
   assign nm2      = count_ff - CW'(2);
   assign lim_w    = (LW'(slim_ff) < LW'(STACK_DEPTH)) ? LW'(slim_ff) : LW'(STACK_DEPTH);
   assign eg       = (GEW'(gin_ff) < GEW'(GLOBALS_DEPTH)) ? GEW'(gin_ff) : GEW'(GLOBALS_DEPTH);
   assign ovf      = LW'(count_ff) >= lim_w;
   assign nz       = (count_ff == '0);
   assign lt2      = (count_ff < CW'(2));
   assign badg     = issue.operand[31] || (issue.operand >= 32'(eg));
   assign plt      = (32'(count_ff) < issue.operand);
   assign clearing = (state_ff == S_CLEAR);
   assign rsp      = rsp_ff;

   always_comb begin
      fst = ST_OK;
      unique case (issue.cls)
         CL_HALT:    fst = ST_HALTED;
         CL_LOADG:   fst = ovf ? ST_OVF : (badg ? ST_BADG : ST_OK);
         CL_PUSHC:   fst = ovf ? ST_OVF : ST_OK;
         CL_STOREG:  fst = nz ? ST_UNDF : (badg ? ST_BADG : ST_OK);
         CL_POP:     fst = nz ? ST_UNDF : ST_OK;
         CL_SWAP:    fst = lt2 ? ST_UNDF : ST_OK;
         CL_DUP:     fst = ovf ? ST_OVF : (nz ? ST_UNDF : ST_OK);
         CL_BRANCH:  fst = ((issue.need == 2'd2) ? lt2 : nz) ? ST_UNDF : ST_OK;
         CL_BINOP:   fst = lt2 ? ST_UNDF : ST_OK;
         CL_UNOP:    fst = nz ? ST_UNDF : ST_OK;
         CL_PRINT:   fst = issue.print_bad ? ST_BADPRN : (plt ? ST_UNDF : ST_OK);
         CL_INVALID: fst = ST_INVOP;
         default:    fst = ST_OK;
      endcase
   end

   always_comb begin
      case (op_ff)
         OP_ADD:  alu = a_ff + b_ff;
         OP_SUB:  alu = a_ff - b_ff;
         OP_MUL:  alu = a_ff * b_ff;
         OP_AND:  alu = 32'((a_ff != 32'd0) && (b_ff != 32'd0));
         OP_OR:   alu = 32'((a_ff != 32'd0) || (b_ff != 32'd0));
         OP_CMP:  alu = a_ff - b_ff;
         OP_EQ:   alu = 32'(a_ff == b_ff);
         OP_NE:   alu = 32'(a_ff != b_ff);
         OP_LT:   alu = 32'($signed(a_ff) < $signed(b_ff));
         OP_LE:   alu = 32'(!($signed(b_ff) < $signed(a_ff)));
         OP_GT:   alu = 32'($signed(b_ff) < $signed(a_ff));
         OP_GE:   alu = 32'(!($signed(a_ff) < $signed(b_ff)));
         default: alu = 32'd0;
      endcase
      case (op_ff)
         OP_BR_EQ: taken = (a_ff == b_ff);
         OP_BR_NE: taken = (a_ff != b_ff);
         OP_BR_LT: taken = $signed(a_ff) < $signed(b_ff);
         OP_BR_LE: taken = !($signed(b_ff) < $signed(a_ff));
         OP_BR_GT: taken = $signed(b_ff) < $signed(a_ff);
         OP_BR_GE: taken = !($signed(a_ff) < $signed(b_ff));
         OP_BR_Z:  taken = (b_ff == 32'd0);
         default:  taken = (b_ff != 32'd0);
      endcase
   end

   assign ma = a_ff[31] ? (32'd0 - a_ff) : a_ff;
   assign mb = b_ff[31] ? (32'd0 - b_ff) : b_ff;
   // restoring divide step: b_ff holds the divisor magnitude
   assign dt = {rem_ff, quo_ff[31]};
   assign dd = dt - {1'b0, b_ff};
   assign dv = (op_ff == OP_DIV) ? quo_ff : rem_ff;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      clr_in   = clr_ff;
      op_in    = op_ff;
      cls_in   = cls_ff;
      need_in  = need_ff;
      imm_in   = imm_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      res_in   = res_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      sign_in  = sign_ff;
      pidx_in  = pidx_ff;
      pbase_in = pbase_ff;
      rsp_in   = rsp_ff;
      s_we     = 1'b0;
      s_waddr  = nm1[SAW-1:0];
      s_wdata  = b_ff;
      s_re     = 1'b0;
      s_raddr  = nm1[SAW-1:0];
      g_we     = 1'b0;
      g_waddr  = imm_ff[GAW-1:0];
      g_wdata  = b_ff;
      g_re     = 1'b0;
      g_raddr  = issue.operand[GAW-1:0];
      rsp_push   = 1'b0;
      issue_take = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            g_we    = 1'b1;
            g_waddr = clr_ff;
            g_wdata = 32'd0;
            clr_in  = clr_ff + GAW'(1);
            if (clr_ff == GAW'(GLOBALS_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (issue_valid) begin
               issue_take         = 1'b1;
               op_in              = issue.op;
               cls_in             = issue.cls;
               need_in            = issue.need;
               imm_in             = issue.operand;
               rsp_in.status      = fst;
               rsp_in.pc_delta    = 32'd0;
               rsp_in.print_valid = 1'b0;
               rsp_in.print_value = 32'd0;
               rsp_in.last        = 1'b1;
               state_in           = S_RESP;
               if (fst == ST_OK) begin
                  unique case (issue.cls)
                     CL_NOP:   rsp_in.pc_delta = 32'd1;
                     CL_GOTO:  rsp_in.pc_delta = issue.operand;
                     CL_PUSHC: begin
                        s_we            = 1'b1;
                        s_waddr         = count_ff[SAW-1:0];
                        s_wdata         = issue.operand;
                        count_in        = count_ff + CW'(1);
                        rsp_in.pc_delta = 32'd2;
                     end
                     CL_POP: begin
                        count_in        = nm1;
                        rsp_in.pc_delta = 32'd1;
                     end
                     CL_LOADG: begin
                        g_re     = 1'b1;
                        state_in = S_GETG;
                     end
                     CL_PRINT: begin
                        pidx_in  = count_ff - issue.operand[CW-1:0];
                        pbase_in = count_ff - issue.operand[CW-1:0];
                        state_in = S_PREAD;
                     end
                     default: begin
                        s_re     = 1'b1;
                        state_in = S_GETB;
                     end
                  endcase
               end
            end
         end
         S_GETG: begin
            s_we            = 1'b1;
            s_waddr         = count_ff[SAW-1:0];
            s_wdata         = g_rdata;
            count_in        = count_ff + CW'(1);
            rsp_in.pc_delta = 32'd2;
            state_in        = S_RESP;
         end
         S_GETB: begin
            b_in = s_rdata;
            a_in = 32'd0;
            if (need_ff == 2'd2) begin
               s_re     = 1'b1;
               s_raddr  = nm2[SAW-1:0];
               state_in = S_GETA;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_GETA: begin
            a_in     = s_rdata;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            rsp_in.pc_delta = 32'd1;
            state_in        = S_RESP;
            case (cls_ff)
               CL_STOREG: begin
                  g_we            = 1'b1;
                  count_in        = nm1;
                  rsp_in.pc_delta = 32'd2;
               end
               CL_DUP: begin
                  s_we     = 1'b1;
                  s_waddr  = count_ff[SAW-1:0];
                  count_in = count_ff + CW'(1);
               end
               CL_UNOP: begin
                  s_we    = 1'b1;
                  s_wdata = (op_ff == OP_NEG) ? (32'd0 - b_ff) : 32'(b_ff == 32'd0);
               end
               CL_SWAP: begin
                  s_we     = 1'b1;
                  s_wdata  = a_ff;
                  state_in = S_SWAP;
               end
               CL_BRANCH: begin
                  count_in        = count_ff - CW'(need_ff);
                  rsp_in.pc_delta = taken ? imm_ff : 32'd2;
               end
               default: begin
                  if ((op_ff == OP_DIV || op_ff == OP_MOD) && b_ff == 32'd0) begin
                     rsp_in.status   = ST_DIVZ;
                     rsp_in.pc_delta = 32'd0;
                  end else if (op_ff == OP_DIV || op_ff == OP_MOD) begin
                     quo_in   = ma;
                     rem_in   = 32'd0;
                     b_in     = mb;
                     cnt_in   = 5'd0;
                     sign_in  = (op_ff == OP_DIV) ? (a_ff[31] ^ b_ff[31]) : a_ff[31];
                     state_in = S_DIV;
                  end else if (op_ff == OP_POW && b_ff[31]) begin
                     if (a_ff == 32'd1) begin
                        res_in = 32'd1;
                     end else if (a_ff == 32'hFFFF_FFFF) begin
                        res_in = b_ff[0] ? 32'hFFFF_FFFF : 32'd1;
                     end else begin
                        res_in = 32'd0;
                     end
                     state_in = S_WRITE;
                  end else if (op_ff == OP_POW) begin
                     // res: running product, rem: base, quo: exponent
                     res_in   = 32'd1;
                     rem_in   = a_ff;
                     quo_in   = b_ff;
                     state_in = S_POW;
                  end else begin
                     res_in   = alu;
                     state_in = S_WRITE;
                  end
               end
            endcase
         end
         S_DIV: begin
            if (!dd[32]) begin
               rem_in = dd[31:0];
            end else begin
               rem_in = dt[31:0];
            end
            quo_in = {quo_ff[30:0], !dd[32]};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = S_SIGN;
            end
         end
         S_SIGN: begin
            res_in   = sign_ff ? (32'd0 - dv) : dv;
            state_in = S_WRITE;
         end
         S_POW: begin
            if (quo_ff == 32'd0) begin
               state_in = S_WRITE;
            end else begin
               if (quo_ff[0]) begin
                  res_in = res_ff * rem_ff;
               end
               rem_in = rem_ff * rem_ff;
               quo_in = {1'b0, quo_ff[31:1]};
            end
         end
         S_WRITE: begin
            s_we            = 1'b1;
            s_waddr         = nm2[SAW-1:0];
            s_wdata         = res_ff;
            count_in        = nm1;
            rsp_in.pc_delta = 32'd1;
            state_in        = S_RESP;
         end
         S_SWAP: begin
            s_we     = 1'b1;
            s_waddr  = nm2[SAW-1:0];
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_push = 1'b1;
            if (!rsp_full) begin
               state_in = S_IDLE;
            end
         end
         S_PREAD: begin
            s_re     = 1'b1;
            s_raddr  = pidx_ff[SAW-1:0];
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            rsp_in.status      = ST_OK;
            rsp_in.pc_delta    = 32'd2;
            rsp_in.print_valid = 1'b1;
            rsp_in.print_value = s_rdata;
            rsp_in.last        = (pidx_ff == nm1);
            state_in           = S_PPUSH;
         end
         S_PPUSH: begin
            rsp_push = 1'b1;
            if (!rsp_full) begin
               if (rsp_ff.last) begin
                  count_in = pbase_ff;
                  state_in = S_IDLE;
               end else begin
                  pidx_in  = pidx_ff + CW'(1);
                  state_in = S_PREAD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         count_ff <= '0;
         clr_ff   <= '0;
         gin_ff   <= 9'd0;
         slim_ff  <= 11'd1024;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         clr_ff   <= clr_in;
         if (csr_write) begin
            case (csr_index)
               CSR_GLOBALS: gin_ff  <= csr_data[8:0];
               default:     slim_ff <= csr_data;
            endcase
         end
      end
      op_ff    <= op_in;
      cls_ff   <= cls_in;
      need_ff  <= need_in;
      imm_ff   <= imm_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      res_ff   <= res_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      sign_ff  <= sign_in;
      pidx_ff  <= pidx_in;
      pbase_ff <= pbase_in;
      rsp_ff   <= rsp_in;
   end

   smeu_ram #(
      .WIDTH(32),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (s_we),
      .wr_addr(s_waddr),
      .wr_data(s_wdata),
      .rd_en  (s_re),
      .rd_addr(s_raddr),
      .rd_data(s_rdata)
   );

   smeu_ram #(
      .WIDTH(32),
      .DEPTH(GLOBALS_DEPTH)
   ) u_globals (
      .clock  (clock),
      .wr_en  (g_we),
      .wr_addr(g_waddr),
      .wr_data(g_wdata),
      .rd_en  (g_re),
      .rd_addr(g_raddr),
      .rd_data(g_rdata)
   );

endmodule

// ===== hw/rtl/stack_machine_execute_unit.sv =====
// Top level of the stack machine execute unit.
// Requests: one instruction per request (req_type opcode, req_operand immediate),
//   taken while req_push is high and req_full is low.
// Results: the oldest result sits on the rsp_ ports while rsp_empty is low and
//   leaves at rsp_pop; rsp_last marks the final result of a request.
// CSRs: csr_write with csr_index 0 sets the number of valid globals, 1 the stack
//   limit; write them only while the unit is idle.
// Sequencing: a request is decoded into a two-entry queue; the sequencer then
//   runs div and mod in the divider (one quotient bit a cycle), pow with two
//   multipliers (one exponent bit a cycle) and each printed value in turn as a
//   stack read, a wait and a push, bound by the stack RAM read port.
//   One request runs at a time; the front queue accepts up to two more meanwhile.
// Reset: stack count and CSRs reset; the globals RAM is then zeroed one entry a
//   cycle, all GLOBALS_DEPTH entries (256 by default), with req_full held high.
// Stall: results wait in a two-entry queue; when it is full the sequencer holds
//   its result and the front queue fills, raising req_full.
module stack_machine_execute_unit import smeu_pkg::*; #(
   parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
   parameter int GLOBALS_DEPTH = GLOBALS_DEPTH_DEF,
   parameter int MAX_PRINT     = MAX_PRINT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [5:0]  req_type,
   input  logic [31:0] req_operand,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_pc_delta,
   output logic        rsp_print_valid,
   output logic [31:0] rsp_print_value,
   output logic        rsp_last,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);

   smeu_issue_type issue;
   logic           issue_valid, issue_take, clearing;
   smeu_rsp_type   rsp_w, rsp_q;
   logic           rsp_push, rsp_full;

   smeu_front #(
      .MAX_PRINT(MAX_PRINT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (clearing),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_type   (req_type),
      .req_operand(req_operand),
      .issue_valid(issue_valid),
      .issue_take (issue_take),
      .issue      (issue)
   );

   smeu_back #(
      .STACK_DEPTH  (STACK_DEPTH),
      .GLOBALS_DEPTH(GLOBALS_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .clearing   (clearing),
      .issue_valid(issue_valid),
      .issue_take (issue_take),
      .issue      (issue),
      .rsp_push   (rsp_push),
      .rsp_full   (rsp_full),
      .rsp        (rsp_w)
   );

   smeu_fifo #(
      .WIDTH($bits(smeu_rsp_type))
   ) u_rsp_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (rsp_push),
      .full   (rsp_full),
      .wr_data(rsp_w),
      .empty  (rsp_empty),
      .pop    (rsp_pop),
      .rd_data(rsp_q)
   );

   assign rsp_status      = rsp_q.status;
   assign rsp_pc_delta    = rsp_q.pc_delta;
   assign rsp_print_valid = rsp_q.print_valid;
   assign rsp_print_value = rsp_q.print_value;
   assign rsp_last        = rsp_q.last;

endmodule

// ===== hw/rtl/smeu_checker.sv =====
// Port-level checker of the stack machine execute unit and its bind.
`include "stack_machine_execute_unit_macros.svh"

module smeu_checker import smeu_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_pc_delta,
   input logic        rsp_print_valid,
   input logic [31:0] rsp_print_value,
   input logic        rsp_last
);

   `SMEU_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, rsp_empty && req_full)
   `SMEU_ASSERT_IMPLY(a_fault_no_advance, clock, reset,
      !rsp_empty && rsp_status != ST_OK, rsp_pc_delta == 32'd0 && !rsp_print_valid)
   `SMEU_ASSERT_IMPLY(a_plain_single, clock, reset,
      !rsp_empty && !rsp_print_valid, rsp_last && rsp_print_value == 32'd0)
   `SMEU_ASSERT_IMPLY(a_print_ok, clock, reset,
      !rsp_empty && rsp_print_valid, rsp_status == ST_OK && rsp_pc_delta == 32'd2)
   `SMEU_ASSERT_NEXT(a_rsp_hold, clock, reset,
      !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_print_value))

endmodule

bind stack_machine_execute_unit smeu_checker u_checker (.*);

// ===== bench/tb_top.sv =====
// Self-checking testbench of the stack machine execute unit.
module tb_top;
   import smeu_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [5:0]  req_type = '0;
   logic [31:0] req_operand = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_pc_delta;
   logic        rsp_print_valid;
   logic [31:0] rsp_print_value;
   logic        rsp_last;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [10:0] csr_data = '0;

   stack_machine_execute_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [31:0] mdl_stack [1024];
   logic [31:0] mdl_globals [256];
   int unsigned mdl_count;
   int unsigned mdl_nglob;
   int unsigned mdl_limit;

   smeu_rsp_type expected_rsps [$];
   int unsigned  mismatches = 0;
   int unsigned  rsp_seen = 0;
   int unsigned  print_seen = 0;
   int unsigned  fault_seen = 0;
   int unsigned  cycles = 0;
   int unsigned  pop_gap = 0;
   bit           idle_on = 1'b1;

   function automatic bit slt(logic [31:0] a, logic [31:0] b);
      return $signed(a) < $signed(b);
   endfunction

   function automatic logic [31:0] ipow(logic [31:0] b, logic [31:0] e);
      logic [31:0] r;
      r = 32'd1;
      if (e[31]) begin
         if (b == 32'd1) return 32'd1;
         if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
         return 32'd0;
      end
      while (e != 0) begin
         if (e[0]) r = r * b;
         b = b * b;
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic logic [2:0] binop(logic [5:0] op, logic [31:0] a, logic [31:0] b,
                                        output logic [31:0] r);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      r = '0;
      case (op)
         OP_ADD: r = a + b;
         OP_SUB, OP_CMP: r = a - b;
         OP_MUL: r = a * b;
         OP_DIV: begin
            if (b == 0) return ST_DIVZ;
            q = ma / mb;
            r = (a[31] != b[31]) ? -q : q;
         end
         OP_MOD: begin
            if (b == 0) return ST_DIVZ;
            q = ma % mb;
            r = a[31] ? -q : q;
         end
         OP_POW: r = ipow(a, b);
         OP_AND: r = (a != 0 && b != 0);
         OP_OR:  r = (a != 0 || b != 0);
         OP_EQ:  r = (a == b);
         OP_NE:  r = (a != b);
         OP_LT:  r = slt(a, b);
         OP_LE:  r = !slt(b, a);
         OP_GT:  r = slt(b, a);
         default: r = !slt(a, b);
      endcase
      return ST_OK;
   endfunction

   task automatic predict_instr(logic [5:0] op, logic [31:0] imm);
      smeu_rsp_type e;
      int unsigned n, lim, glim, need;
      logic [2:0] st;
      logic [31:0] delta, r, a, b, t;
      bit taken;
      n = mdl_count;
      lim = mdl_limit < 1024 ? mdl_limit : 1024;
      glim = mdl_nglob < 256 ? mdl_nglob : 256;
      st = ST_OK;
      delta = 32'd1;
      taken = 1'b0;
      e = '0;
      e.last = 1'b1;
      if (op == OP_HALT) begin
         e.status = ST_HALTED;
         expected_rsps.push_back(e);
         return;
      end
      if (op == OP_NOP) begin
      end else if (op == OP_LOADG || op == OP_PUSHC) begin
         if (n >= lim) st = ST_OVF;
         else if (op == OP_LOADG && (imm[31] || imm >= glim)) st = ST_BADG;
         else begin
            mdl_stack[n] = (op == OP_LOADG) ? mdl_globals[imm[7:0]] : imm;
            mdl_count = n + 1;
            delta = 32'd2;
         end
      end else if (op == OP_STOREG) begin
         if (n == 0) st = ST_UNDF;
         else if (imm[31] || imm >= glim) st = ST_BADG;
         else begin
            mdl_globals[imm[7:0]] = mdl_stack[n-1];
            mdl_count = n - 1;
            delta = 32'd2;
         end
      end else if (op == OP_POP) begin
         if (n == 0) st = ST_UNDF; else mdl_count = n - 1;
      end else if (op == OP_SWAP) begin
         if (n < 2) st = ST_UNDF;
         else begin
            t = mdl_stack[n-1];
            mdl_stack[n-1] = mdl_stack[n-2];
            mdl_stack[n-2] = t;
         end
      end else if (op == OP_DUP) begin
         if (n >= lim) st = ST_OVF;
         else if (n == 0) st = ST_UNDF;
         else begin
            mdl_stack[n] = mdl_stack[n-1];
            mdl_count = n + 1;
         end
      end else if (op == OP_GOTO) begin
         delta = imm;
      end else if (op >= OP_BR_EQ && op <= OP_BR_NZ) begin
         need = (op >= OP_BR_Z) ? 1 : 2;
         if (n < need) st = ST_UNDF;
         else begin
            b = mdl_stack[n-1];
            a = (need == 2) ? mdl_stack[n-2] : 32'd0;
            case (op)
               OP_BR_EQ: taken = a == b;
               OP_BR_NE: taken = a != b;
               OP_BR_LT: taken = slt(a, b);
               OP_BR_LE: taken = !slt(b, a);
               OP_BR_GT: taken = slt(b, a);
               OP_BR_GE: taken = !slt(a, b);
               OP_BR_Z:  taken = b == 0;
               default:  taken = b != 0;
            endcase
            mdl_count = n - need;
            delta = taken ? imm : 32'd2;
         end
      end else if (op >= OP_ADD && op <= OP_GE) begin
         if (n < 2) st = ST_UNDF;
         else begin
            st = binop(op, mdl_stack[n-2], mdl_stack[n-1], r);
            if (st == ST_OK) begin
               mdl_stack[n-2] = r;
               mdl_count = n - 1;
            end
         end
      end else if (op == OP_NEG || op == OP_NOT) begin
         if (n == 0) st = ST_UNDF;
         else mdl_stack[n-1] = (op == OP_NEG) ? -mdl_stack[n-1] : (mdl_stack[n-1] == 0);
      end else if (op == OP_PRINT) begin
         if (imm[31] || imm == 0 || imm > 16) st = ST_BADPRN;
         else if (n < imm) st = ST_UNDF;
         else begin
            for (int i = 0; i < imm; i++) begin
               e.status = ST_OK;
               e.pc_delta = 32'd2;
               e.print_valid = 1'b1;
               e.print_value = mdl_stack[n - imm + i];
               e.last = (i + 1 == imm);
               expected_rsps.push_back(e);
            end
            mdl_count = n - imm;
            return;
         end
      end else begin
         st = ST_INVOP;
      end
      if (st != ST_OK) delta = '0;
      e.status = smeu_status_type'(st);
      e.pc_delta = delta;
      expected_rsps.push_back(e);
   endtask

   task automatic send_instr(logic [5:0] op, logic [31:0] imm);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_type <= op;
      req_operand <= imm;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_instr(op, imm);
   endtask

   task automatic drain_and_settle();
      req_push <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int unsigned val);
      drain_and_settle();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val[10:0];
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_GLOBALS) mdl_nglob = val; else mdl_limit = val;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      smeu_rsp_type e;
      if (reset) rsp_pop <= 1'b0;
      else begin
         if (rsp_pop && !rsp_empty) begin
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result status %0d", rsp_status);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_print_valid) print_seen++;
               if (e.status != ST_OK) fault_seen++;
               if (rsp_status !== e.status || rsp_pc_delta !== e.pc_delta
                   || rsp_print_valid !== e.print_valid
                   || rsp_print_value !== e.print_value || rsp_last !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp st %0d d %0d pv %0b v %h l %0b, got st %0d d %0d pv %0b v %h l %0b",
                              e.status, $signed(e.pc_delta), e.print_valid, e.print_value, e.last,
                              rsp_status, $signed(rsp_pc_delta), rsp_print_valid,
                              rsp_print_value, rsp_last);
               end
            end
         end
         if (idle_on && pop_gap == 0 && $urandom_range(0, 3) == 0)
            pop_gap = $urandom_range(1, 5);
         if (pop_gap != 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 4);
         3: return -$urandom_range(1, 4);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_instr(OP_POP, 0);
      send_instr(OP_SWAP, 0);
      send_instr(OP_PRINT, 0);
      send_instr(OP_PRINT, 32'hFFFF_FFFF);
      send_instr(OP_PRINT, 17);
      send_instr(OP_LOADG, 0);
      send_instr(OP_PUSHC, 32'h8000_0000);
      send_instr(OP_PUSHC, 32'hFFFF_FFFF);
      send_instr(OP_DIV, 0);
      send_instr(OP_PUSHC, 32'h8000_0000);
      send_instr(OP_PUSHC, 32'hFFFF_FFFF);
      send_instr(OP_MOD, 0);
      send_instr(OP_PUSHC, 0);
      send_instr(OP_DIV, 0);
      send_instr(OP_PUSHC, 32'hFFFF_FFFF);
      send_instr(OP_PUSHC, 32'hFFFF_FFFB);
      send_instr(OP_POW, 0);
      send_instr(OP_DUP, 0);
      send_instr(OP_STOREG, 0);
      send_instr(OP_HALT, 0);
      send_instr(6'd63, 32'h7FFF_FFFF);
      send_instr(OP_GOTO, 32'h8000_0000);
      send_instr(OP_PRINT, 3);
   endtask

   task automatic test_limits();
      write_csr(CSR_GLOBALS, 256);
      write_csr(CSR_LIMIT, 1);
      send_instr(OP_PUSHC, 7);
      send_instr(OP_DUP, 0);
      send_instr(OP_LOADG, 300);
      send_instr(OP_STOREG, 255);
      send_instr(OP_LOADG, 255);
      send_instr(OP_STOREG, 256);
      send_instr(OP_PRINT, 1);
      write_csr(CSR_LIMIT, 0);
      send_instr(OP_PUSHC, 1);
      write_csr(CSR_LIMIT, 2047);
      for (int i = 0; i < 16; i++) send_instr(OP_PUSHC, $urandom);
      send_instr(OP_PRINT, 16);
   endtask

   task automatic test_random(int unsigned items);
      logic [5:0] op;
      for (int i = 0; i < items; i++) begin
         if (mdl_count > 40) op = $urandom_range(0, 9) < 5 ? OP_PRINT : OP_POP;
         else if (mdl_count < 3 && $urandom_range(0, 1)) op = OP_PUSHC;
         else if ($urandom_range(0, 9) == 0) op = 6'($urandom_range(35, 63));
         else op = 6'($urandom_range(0, 34));
         case (op)
            OP_LOADG, OP_STOREG:
               send_instr(op, $urandom_range(0, 5) == 0 ? rand_word() : $urandom_range(0, 20));
            OP_PRINT:
               send_instr(op, $urandom_range(0, 7) == 0 ? rand_word() :
                              $urandom_range(1, mdl_count > 16 ? 16 : mdl_count + 1));
            default: send_instr(op, rand_word());
         endcase
      end
   endtask

   initial begin
      mdl_count = 0;
      mdl_nglob = 0;
      mdl_limit = 1024;
      for (int i = 0; i < 256; i++) mdl_globals[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_limits();
      write_csr(CSR_GLOBALS, 16);
      write_csr(CSR_LIMIT, 24);
      test_random(200);
      drain_and_settle();
      write_csr(CSR_GLOBALS, 0);
      write_csr(CSR_LIMIT, 1024);
      test_random(150);
      write_csr(CSR_GLOBALS, 21);
      idle_on = 1'b0;
      test_random(150);
      drain_and_settle();
      $display("Ran %0d results (%0d printed values, %0d faults) over varied CSR settings.",
               rsp_seen, print_seen, fault_seen);
      if (mismatches == 0 && expected_rsps.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
